### sv/nsl_pkg.sv
// Package for the nearest-smaller-left stream block.
// Holds the stack depth, the word width and the cell status type.
// No dependencies.
package nsl_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;

    typedef struct packed {
        logic keep;
        logic is_top;
    } cell_status_t;

endpackage

### sv/nearest_smaller_left_core.sv
// A result word is registered when its input word is accepted and is shown in the next cycle.
// One word is taken per cycle unless the output is stalled; every cell compares against the new value
// at once, so the row of cells settles a whole pop and push together.
// Reset clears every cell valid bit (empty stack) and the output valid flag.
// Top level of the nearest-smaller-left block; depends on nsl_pkg and nsl_cell.
module nearest_smaller_left_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [nsl_pkg::DATA_W-1:0]   value,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic signed [nsl_pkg::DATA_W-1:0]   nearest,
    output logic                                overflow,
    output logic                                last_out
);
    import nsl_pkg::*;

    cell_status_t               status_vec [STACK_DEPTH];
    logic [DATA_W-1:0]          top_vec    [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]     keep_vec;
    logic [STACK_DEPTH-1:0]     is_top_vec;
    logic [DATA_W-1:0]          nearest_or;
    logic                       accept;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       found_reg;
    logic signed [DATA_W-1:0]   nearest_reg;
    logic                       overflow_reg;
    logic                       last_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic keep_below;
            logic keep_above;

            if (gi == 0)
            begin : g_bottom
                assign keep_below = 1'b1;
            end
            else
            begin : g_mid_below
                assign keep_below = keep_vec[gi-1];
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_top
                assign keep_above = 1'b0;
            end
            else
            begin : g_mid_above
                assign keep_above = keep_vec[gi+1];
            end

            nsl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .accept     (accept),
                .value      (value),
                .last_in    (last_in),
                .keep_below (keep_below),
                .keep_above (keep_above),
                .status     (status_vec[gi]),
                .top_data   (top_vec[gi])
            );

            assign keep_vec[gi]   = status_vec[gi].keep;
            assign is_top_vec[gi] = status_vec[gi].is_top;
        end
    endgenerate

    always_comb
    begin
        nearest_or = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            nearest_or = nearest_or | top_vec[i];
        end
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg    <= keep_vec[0];
            nearest_reg  <= nearest_or;
            overflow_reg <= keep_vec[STACK_DEPTH-1];
            last_reg     <= last_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign nearest   = nearest_reg;
    assign overflow  = overflow_reg;
    assign last_out  = last_reg;

`ifndef NO_ASSERTIONS
    a_one_top: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(is_top_vec))
        else $error("More than one cell claims the stack top.");

    a_keep_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, keep_vec} & ({1'b0, keep_vec} + 1'b1)) == '0))
        else $error("Kept cells do not form a prefix of the stack.");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in) |=> (keep_vec == '0))
        else $error("Stack not empty after a last word.");

    a_overflow_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflow_reg) |-> found_reg)
        else $error("Overflow reported without a smaller entry.");
`endif

endmodule

### sv/nsl_cell.sv
// One stack cell of the nearest-smaller-left block.
// Holds one entry and its valid bit; depends on nsl_pkg.
// Neighbors exchange their keep flags every cycle.
module nsl_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic signed [nsl_pkg::DATA_W-1:0]   value,
    input  logic                                last_in,
    input  logic                                keep_below,
    input  logic                                keep_above,
    output nsl_pkg::cell_status_t               status,
    output logic        [nsl_pkg::DATA_W-1:0]   top_data
);
    import nsl_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DATA_W-1:0]  data_reg;
    logic signed [DATA_W-1:0]  data_next;
    logic                      keep;
    logic                      push;

    assign keep = valid_reg && (data_reg < value);
    assign push = !keep && keep_below;

    assign status.keep   = keep;
    assign status.is_top = keep && !keep_above;
    assign top_data      = status.is_top ? data_reg : '0;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = !last_in && (keep || push);
            if (push)
            begin
                data_next = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### sim/tb_top.sv
// Self-checking testbench for nearest_smaller_left_core, a streaming monotonic stack.
// It predicts each result from its own copy of the stack and compares every field.
// Depends on nsl_pkg and the RTL of nearest_smaller_left_core.
`timescale 1ns / 1ps

module tb_top;

    import nsl_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_WORDS = 750;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } stream_word_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] nearest;
        logic                     overflow;
        logic                     last;
    } lookup_result_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     last_in   = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     found;
    logic signed [DATA_W-1:0] nearest;
    logic                     overflow;
    logic                     last_out;

    stream_word_t             pending_words[$];
    lookup_result_t           expected_results[$];
    stream_word_t             next_word;
    lookup_result_t           want;

    logic signed [DATA_W-1:0] model_stack[STACK_DEPTH];
    int                       model_depth = 0;

    int cycle_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int overflow_seen   = 0;
    int not_found_seen  = 0;
    int error_count     = 0;
    int tx_gap_left     = 0;
    int tx_quiet        = 0;
    int rx_pause_left   = 0;
    int rx_quiet        = 0;
    int hold_left       = 0;
    int holds_done      = 0;

    nearest_smaller_left_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .nearest   (nearest),
        .overflow  (overflow),
        .last_out  (last_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic lookup_result_t nearest_smaller_of(input logic signed [DATA_W-1:0] v,
                                                          input logic lst);
        lookup_result_t r;
        r = '0;
        while (model_depth > 0 && model_stack[model_depth - 1] >= v)
            model_depth--;
        if (model_depth > 0)
        begin
            r.found   = 1'b1;
            r.nearest = model_stack[model_depth - 1];
        end
        if (model_depth < STACK_DEPTH)
        begin
            model_stack[model_depth] = v;
            model_depth++;
        end
        else
            r.overflow = 1'b1;
        if (lst)
            model_depth = 0;
        r.last = lst;
        return r;
    endfunction

    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            quiet = $urandom_range(30, 80);
            return 0;
        end
        if (r < 62)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_word(input logic signed [DATA_W-1:0] v, input logic lst);
        stream_word_t w;
        w.value = v;
        w.last  = lst;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Sender: keeps a word steady while it is stalled, then loads the next one after a random gap, often none.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            value       <= '0;
            last_in     <= 1'b0;
            tx_gap_left <= 0;
            words_sent  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.insert(expected_results.size(),
                                        nearest_smaller_of(value, last_in));
                words_sent <= words_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap_left != 0)
                begin
                    tx_gap_left <= tx_gap_left - 1;
                    in_valid    <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    in_valid    <= 1'b1;
                    value       <= next_word.value;
                    last_in     <= next_word.last;
                    tx_gap_left <= pick_idle(tx_quiet);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs so that the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && words_sent >= 150) ||
                 (holds_done == 1 && words_sent >= 450))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver: checks each accepted result word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            rx_pause_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked <= results_checked + 1;
                if (expected_results.size() == 0)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display(
                            "tb: unexpected result found=%0b nearest=%0d overflow=%0b last=%0b",
                            found, nearest, overflow, last_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (!want.found)
                        not_found_seen <= not_found_seen + 1;
                    if (want.overflow)
                        overflow_seen <= overflow_seen + 1;
                    if (found !== want.found || nearest !== want.nearest ||
                        overflow !== want.overflow || last_out !== want.last)
                    begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display(
                                {"tb: mismatch at result %0d: ",
                                 "want %0b/%0d/%0b/%0b got %0b/%0d/%0b/%0b"},
                                results_checked, want.found, want.nearest, want.overflow,
                                want.last, found, nearest, overflow, last_out);
                    end
                end
            end
            if (rx_pause_left > 0)
                rx_pause_left = rx_pause_left - 1;
            else
                rx_pause_left = pick_idle(rx_quiet);
            out_stall <= (hold_left != 0) || (rx_pause_left != 0);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int kind;
        int len;
        int base;
        int step;
        int i;

        // Directed words: empty stack, extremes, equal values, last marks, alternating bits.
        add_word(32'sd0, 1'b0);
        add_word(32'sh8000_0000, 1'b0);
        add_word(32'sh7FFF_FFFF, 1'b0);
        add_word(32'sh7FFF_FFFF, 1'b0);
        add_word(-32'sd1, 1'b0);
        add_word(32'sh7FFF_FFFF, 1'b0);
        add_word(32'sd5, 1'b0);
        add_word(32'sd5, 1'b1);
        add_word(32'sd5, 1'b0);
        add_word(32'sd3, 1'b0);
        add_word(32'sd7, 1'b0);
        add_word(32'sd7, 1'b0);
        add_word(32'sd3, 1'b0);
        add_word(32'sh8000_0000, 1'b1);
        add_word(32'sh5555_5555, 1'b0);
        add_word(32'shAAAA_AAAA, 1'b0);
        add_word(32'sd1, 1'b0);
        add_word(32'sh5555_5555, 1'b0);
        add_word(-32'sd1, 1'b1);
        add_word(32'sh7FFF_FFFF, 1'b1);

        while (pending_words.size() < 20 + RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                len = $urandom_range(1, 30);
                for (i = 0; i < len; i++)
                    add_word(int'($urandom_range(0, 16)) - 8, i == len - 1);
            end
            else if (kind < 67)
            begin
                len = $urandom_range(1, 40);
                for (i = 0; i < len; i++)
                    add_word($urandom, i == len - 1);
            end
            else if (kind < 75)
            begin
                // Mostly rising run that is often long enough to fill the stack and have pushes refused.
                len  = $urandom_range(62, 100);
                base = 32'sh8000_0000 + int'($urandom_range(0, 1000));
                step = $urandom_range(1, 1 << 20);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 5)
                        add_word(base + (i / 2) * step, i == len - 1);
                    else
                        add_word(base + i * step, i == len - 1);
                end
            end
            else if (kind < 88)
            begin
                len  = $urandom_range(1, 20);
                base = $urandom;
                for (i = 0; i < len; i++)
                    add_word(base - i * int'($urandom_range(0, 3)), i == len - 1);
            end
            else
            begin
                len = $urandom_range(1, 15);
                for (i = 0; i < len; i++)
                    add_word($urandom, $urandom_range(0, 99) < 30);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d words streamed, %0d results checked, %0d with no smaller value,",
                 words_sent, results_checked, not_found_seen);
        $display("tb: %0d refused pushes on a full stack, %0d long receiver hold-offs",
                 overflow_seen, holds_done);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
